// ===== sv/screen_ray_direction_generator_assert.svh =====
// Assertion macros used by the ray direction generator checker.
`ifndef SCREEN_RAY_DIRECTION_GENERATOR_ASSERT_SVH
`define SCREEN_RAY_DIRECTION_GENERATOR_ASSERT_SVH

// same-cycle implication
`define SRDG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srdg assertion failed");

// next-cycle implication
`define SRDG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srdg assertion failed");

`endif

// ===== sv/srdg_pkg.sv =====
// Types and constants of the screen ray direction generator.
package srdg_pkg;
   localparam int COORD_BITS    = 16;
   localparam int COEFF_BITS    = 32;
   localparam int DIR_FRAC_BITS = 14;
   localparam int COORD_FRAC    = 4;
   localparam int NORM_BITS     = 30;
   localparam int TABLE_DEPTH   = 9;
   localparam int IDX_BITS      = 4;
   localparam int DIR_BITS      = DIR_FRAC_BITS + 2;
   localparam int PROD_BITS     = COEFF_BITS + COORD_BITS + 1;
   localparam int SUM_BITS      = PROD_BITS + 2;
   localparam int LEN_BITS      = $clog2(SUM_BITS + 1);
   localparam int SQ_BITS       = 2 * NORM_BITS + 2;
   localparam int ROOT_BITS     = NORM_BITS + 1;
   localparam int SQRT_STEPS    = NORM_BITS + 1;
   localparam int NUM_BITS      = NORM_BITS + DIR_FRAC_BITS + 1;
   localparam int REM_BITS      = NUM_BITS + 1;
   localparam int QUO_BITS      = DIR_BITS;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_RAY   = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type                     opcode;
      logic [IDX_BITS-1:0]            coeff_index;
      logic signed [COEFF_BITS-1:0]   coeff_value;
      logic [COORD_BITS-1:0]          screen_x;
      logic [COORD_BITS-1:0]          screen_y;
   } req_type;

   typedef struct packed {
      logic signed [DIR_BITS-1:0] dir_x;
      logic signed [DIR_BITS-1:0] dir_y;
      logic signed [DIR_BITS-1:0] dir_z;
      logic                       zero_length;
   } rsp_type;

   typedef logic [NORM_BITS-1:0] norm_type;

   typedef struct packed {
      logic           valid;
      logic           zero;
      logic [2:0]     neg;
      norm_type [2:0] vec;
   } vec_type;
endpackage

// ===== sv/screen_ray_direction_generator.sv =====
// Throughput: one item per cycle; every stage advances together while the
// output register is empty or being taken, and req_ready is that same condition.
// Depth set by 7 front stages, 32 root stages and 17 divide stages.
// Reset clears the coefficient table to zero and all valid bits at once.
module screen_ray_direction_generator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  srdg_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output srdg_pkg::rsp_type  rsp_data
);
   import srdg_pkg::*;

   logic                 enable, load, ray;
   vec_type              front_side, sqrt_side;
   logic [SQ_BITS-1:0]   front_rad;
   logic [ROOT_BITS-1:0] sqrt_root;

   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;
   assign load      = req_valid && req_ready && (req_data.opcode == OP_WRITE);
   assign ray       = req_valid && req_ready && (req_data.opcode == OP_RAY);

   srdg_front u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .load     (load),
      .ray      (ray),
      .req_data (req_data),
      .side_out (front_side),
      .rad_out  (front_rad)
   );

   srdg_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .side_in  (front_side),
      .rad_in   (front_rad),
      .side_out (sqrt_side),
      .root_out (sqrt_root)
   );

   srdg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .side_in   (sqrt_side),
      .root_in   (sqrt_root),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );
endmodule

// ===== sv/srdg_front.sv =====
// Coefficient table, products, sums, block scaling and sum of squares.
module srdg_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          load,
   input  logic                          ray,
   input  srdg_pkg::req_type             req_data,
   output srdg_pkg::vec_type             side_out,
   output logic [srdg_pkg::SQ_BITS-1:0]  rad_out
);
   import srdg_pkg::*;

   logic signed [COEFF_BITS-1:0] table_ff [TABLE_DEPTH];
   logic signed [PROD_BITS-1:0]  prod_in  [TABLE_DEPTH];
   logic signed [PROD_BITS-1:0]  prod_ff  [TABLE_DEPTH];
   logic                         s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic signed [SUM_BITS-1:0]   sum_in [3];
   logic signed [SUM_BITS-1:0]   sum_ff [3];
   logic [SUM_BITS-1:0]          mag_in [3];
   logic [SUM_BITS-1:0]          mag3_ff [3];
   logic [SUM_BITS-1:0]          mag4_ff [3];
   logic [SUM_BITS-1:0]          shifted [3];
   logic [2:0]                   neg_in, neg3_ff, neg4_ff;
   logic [LEN_BITS-1:0]          len_in [3];
   logic [LEN_BITS-1:0]          len_ff [3];
   logic [LEN_BITS-1:0]          maxlen_in, maxlen_ff;
   vec_type                      s5_in, s5_ff, s6_ff, s7_ff;
   logic [2*NORM_BITS-1:0]       sq_ff [3];
   logic [SQ_BITS-1:0]           rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) table_ff[i] <= '0;
      end else if (load && req_data.coeff_index < IDX_BITS'(TABLE_DEPTH)) begin
         table_ff[req_data.coeff_index] <= req_data.coeff_value;
      end
   end

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_prod
      logic [COORD_BITS-1:0]       coord;
      logic signed [PROD_BITS-1:0] coef_ext, coord_ext;
      if (g % 3 == 0) begin : g_x
         assign coord = req_data.screen_x;
      end else if (g % 3 == 1) begin : g_y
         assign coord = req_data.screen_y;
      end else begin : g_one
         assign coord = COORD_BITS'(1 << COORD_FRAC);
      end
      assign coef_ext  = PROD_BITS'(table_ff[g]);
      assign coord_ext = $signed(PROD_BITS'(coord));
      assign prod_in[g] = coef_ext * coord_ext;
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         sum_in[l] = SUM_BITS'(prod_ff[3*l]) + SUM_BITS'(prod_ff[3*l+1])
                   + SUM_BITS'(prod_ff[3*l+2]);
         neg_in[l] = sum_ff[l][SUM_BITS-1];
         mag_in[l] = neg_in[l] ? -sum_ff[l] : sum_ff[l];
         len_in[l] = '0;
         for (int b = 0; b < SUM_BITS; b++) begin
            if (mag_in[l][b]) len_in[l] = LEN_BITS'(b + 1);
         end
      end
      maxlen_in = len_ff[0];
      if (len_ff[1] > maxlen_in) maxlen_in = len_ff[1];
      if (len_ff[2] > maxlen_in) maxlen_in = len_ff[2];
      s5_in.valid = s4_valid_ff;
      s5_in.zero  = (maxlen_ff == '0);
      s5_in.neg   = neg4_ff;
      for (int l = 0; l < 3; l++) begin
         if (maxlen_ff > LEN_BITS'(NORM_BITS)) begin
            shifted[l] = mag4_ff[l] >> (maxlen_ff - LEN_BITS'(NORM_BITS));
         end else begin
            shifted[l] = mag4_ff[l] << (LEN_BITS'(NORM_BITS) - maxlen_ff);
         end
         s5_in.vec[l] = shifted[l][NORM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_ff.valid <= 1'b0;
         s6_ff.valid <= 1'b0;
         s7_ff.valid <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= ray;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_ff       <= s5_in;
         s6_ff       <= s5_ff;
         s7_ff       <= s6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff   <= prod_in;
         sum_ff    <= sum_in;
         mag3_ff   <= mag_in;
         neg3_ff   <= neg_in;
         len_ff    <= len_in;
         mag4_ff   <= mag3_ff;
         neg4_ff   <= neg3_ff;
         maxlen_ff <= maxlen_in;
         for (int l = 0; l < 3; l++) begin
            sq_ff[l] <= (2*NORM_BITS)'(s5_ff.vec[l]) * (2*NORM_BITS)'(s5_ff.vec[l]);
         end
         rad_ff <= SQ_BITS'(sq_ff[0]) + SQ_BITS'(sq_ff[1]) + SQ_BITS'(sq_ff[2]);
      end
   end

   assign side_out = s7_ff;
   assign rad_out  = rad_ff;
endmodule

// ===== sv/srdg_sqrt.sv =====
// Pipelined digit-by-digit square root with round to nearest.
module srdg_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            enable,
   input  srdg_pkg::vec_type               side_in,
   input  logic [srdg_pkg::SQ_BITS-1:0]    rad_in,
   output srdg_pkg::vec_type               side_out,
   output logic [srdg_pkg::ROOT_BITS-1:0]  root_out
);
   import srdg_pkg::*;

   logic [SQ_BITS-1:0] rem_src  [SQRT_STEPS];
   logic [SQ_BITS-1:0] root_src [SQRT_STEPS];
   vec_type            side_src [SQRT_STEPS];
   logic [SQ_BITS-1:0] rem_ff   [SQRT_STEPS];
   logic [SQ_BITS-1:0] root_ff  [SQRT_STEPS];
   vec_type            side_ff  [SQRT_STEPS];
   vec_type            out_side_ff;
   logic [ROOT_BITS-1:0] out_root_ff;

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
      localparam logic [SQ_BITS-1:0] BIT = SQ_BITS'(1) << (2 * (SQRT_STEPS - 1 - g));
      logic [SQ_BITS-1:0] trial, rem_nx, root_nx;
      if (g == 0) begin : g_first
         assign rem_src[g]  = rad_in;
         assign root_src[g] = '0;
         assign side_src[g] = side_in;
      end else begin : g_next
         assign rem_src[g]  = rem_ff[g-1];
         assign root_src[g] = root_ff[g-1];
         assign side_src[g] = side_ff[g-1];
      end
      assign trial = root_src[g] + BIT;
      always_comb begin
         if (rem_src[g] >= trial) begin
            rem_nx  = rem_src[g] - trial;
            root_nx = (root_src[g] >> 1) + BIT;
         end else begin
            rem_nx  = rem_src[g];
            root_nx = root_src[g] >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[g].valid <= 1'b0;
         end else if (enable) begin
            side_ff[g] <= side_src[g];
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[g]  <= rem_nx;
            root_ff[g] <= root_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_side_ff.valid <= 1'b0;
      end else if (enable) begin
         out_side_ff <= side_ff[SQRT_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         if (rem_ff[SQRT_STEPS-1] > root_ff[SQRT_STEPS-1]) begin
            out_root_ff <= ROOT_BITS'(root_ff[SQRT_STEPS-1] + SQ_BITS'(1));
         end else begin
            out_root_ff <= ROOT_BITS'(root_ff[SQRT_STEPS-1]);
         end
      end
   end

   assign side_out = out_side_ff;
   assign root_out = out_root_ff;
endmodule

// ===== sv/srdg_div.sv =====
// Three-lane pipelined restoring divider and signed output register.
module srdg_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            enable,
   input  srdg_pkg::vec_type               side_in,
   input  logic [srdg_pkg::ROOT_BITS-1:0]  root_in,
   output logic                            rsp_valid,
   output srdg_pkg::rsp_type               rsp_data
);
   import srdg_pkg::*;

   logic [REM_BITS-1:0]  rem_src [QUO_BITS][3];
   logic [QUO_BITS-1:0]  quo_src [QUO_BITS][3];
   logic [ROOT_BITS-1:0] div_src [QUO_BITS];
   vec_type              side_src [QUO_BITS];
   logic [REM_BITS-1:0]  rem_ff [QUO_BITS][3];
   logic [QUO_BITS-1:0]  quo_ff [QUO_BITS][3];
   logic [ROOT_BITS-1:0] div_ff [QUO_BITS];
   vec_type              side_ff [QUO_BITS];
   logic [DIR_BITS-1:0]  dir_in [3];
   rsp_type              rsp_in, rsp_ff;
   logic                 valid_ff;

   for (genvar g = 0; g < QUO_BITS; g++) begin : g_step
      localparam int B = QUO_BITS - 1 - g;
      logic [REM_BITS-1:0] dsh;
      logic [REM_BITS-1:0] rem_nx [3];
      logic [QUO_BITS-1:0] quo_nx [3];
      if (g == 0) begin : g_first
         assign div_src[g]  = root_in;
         assign side_src[g] = side_in;
         for (genvar l = 0; l < 3; l++) begin : g_lane
            assign rem_src[g][l] = (REM_BITS'(side_in.vec[l]) << DIR_FRAC_BITS)
                                 + REM_BITS'(root_in >> 1);
            assign quo_src[g][l] = '0;
         end
      end else begin : g_next
         assign div_src[g]  = div_ff[g-1];
         assign side_src[g] = side_ff[g-1];
         assign rem_src[g]  = rem_ff[g-1];
         assign quo_src[g]  = quo_ff[g-1];
      end
      assign dsh = REM_BITS'(div_src[g]) << B;
      always_comb begin
         for (int l = 0; l < 3; l++) begin
            if (rem_src[g][l] >= dsh) begin
               rem_nx[l] = rem_src[g][l] - dsh;
               quo_nx[l] = quo_src[g][l] | (QUO_BITS'(1) << B);
            end else begin
               rem_nx[l] = rem_src[g][l];
               quo_nx[l] = quo_src[g][l];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[g].valid <= 1'b0;
         end else if (enable) begin
            side_ff[g] <= side_src[g];
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[g] <= rem_nx;
            quo_ff[g] <= quo_nx;
            div_ff[g] <= div_src[g];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (side_ff[QUO_BITS-1].zero) begin
            dir_in[l] = '0;
         end else if (side_ff[QUO_BITS-1].neg[l]) begin
            dir_in[l] = -quo_ff[QUO_BITS-1][l];
         end else begin
            dir_in[l] = quo_ff[QUO_BITS-1][l];
         end
      end
      rsp_in.dir_x       = dir_in[0];
      rsp_in.dir_y       = dir_in[1];
      rsp_in.dir_z       = dir_in[2];
      rsp_in.zero_length = side_ff[QUO_BITS-1].zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= side_ff[QUO_BITS-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ===== sv/srdg_checker.sv =====
// Port-level checker for the ray direction generator and its bind.
`include "screen_ray_direction_generator_assert.svh"

module srdg_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input srdg_pkg::rsp_type  rsp_data
);
   import srdg_pkg::*;

   localparam int UNIT = 1 << DIR_FRAC_BITS;

   logic rsp_stall, dirs_zero, dirs_unit;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign dirs_zero = (rsp_data.dir_x == '0) && (rsp_data.dir_y == '0)
                    && (rsp_data.dir_z == '0);
   assign dirs_unit = (rsp_data.dir_x <= UNIT) && (rsp_data.dir_x >= -UNIT)
                    && (rsp_data.dir_y <= UNIT) && (rsp_data.dir_y >= -UNIT)
                    && (rsp_data.dir_z <= UNIT) && (rsp_data.dir_z >= -UNIT);

   `SRDG_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)
   `SRDG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   `SRDG_ASSERT_NOW(a_ready_free, clock, reset, !rsp_valid || rsp_ready, req_ready)
   `SRDG_ASSERT_NOW(a_zero_out, clock, reset, rsp_valid && rsp_data.zero_length, dirs_zero)
   `SRDG_ASSERT_NOW(a_unit_range, clock, reset, rsp_valid, dirs_unit)
endmodule

bind screen_ray_direction_generator srdg_checker u_srdg_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the screen ray direction generator.
`timescale 1ns / 1ps

module tb_top;
   import srdg_pkg::*;

   localparam int LATENCY   = 56;
   localparam int N_RANDOM  = 1000;
   localparam int MAX_CYCLE = 400000;
   localparam int REQ_BITS  = $bits(req_type);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic signed [COEFF_BITS-1:0] camera_coeff [TABLE_DEPTH];
   rsp_type expected_dirs [$];
   int      errors = 0;
   int      cycle_count = 0;
   bit      sending_done = 0;
   bit      quiet_tail = 0;
   bit      long_hold = 0;

   screen_ray_direction_generator dut (.*);

   always #2 clock = ~clock;

   function automatic rsp_type predict_ray(input logic [COORD_BITS-1:0] sx,
                                           input logic [COORD_BITS-1:0] sy);
      logic signed [127:0] s [3];
      logic [127:0]        m [3];
      logic [63:0]         v [3];
      logic [63:0]         sq, rem, root, bitv, q;
      logic [2:0]          neg;
      int                  maxlen, len;
      rsp_type             r;
      r = '0;
      maxlen = 0;
      for (int i = 0; i < 3; i++) begin
         s[i] = 128'(camera_coeff[3*i]) * $signed({1'b0, sx})
              + 128'(camera_coeff[3*i+1]) * $signed({1'b0, sy})
              + 128'(camera_coeff[3*i+2]) * 128'sd16;
         neg[i] = s[i][127];
         m[i] = neg[i] ? -s[i] : s[i];
         len = 0;
         for (int b = 0; b < 128; b++) if (m[i][b]) len = b + 1;
         if (len > maxlen) maxlen = len;
      end
      if (maxlen == 0) begin
         r.zero_length = 1'b1;
         return r;
      end
      for (int i = 0; i < 3; i++) begin
         if (maxlen > NORM_BITS) v[i] = 64'(m[i] >> (maxlen - NORM_BITS));
         else v[i] = 64'(m[i] << (NORM_BITS - maxlen));
         v[i] &= (64'd1 << NORM_BITS) - 1;
      end
      sq = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
      rem = sq;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      if (rem > root) root++;
      q = ((v[0] << DIR_FRAC_BITS) + (root >> 1)) / root;
      r.dir_x = neg[0] ? -DIR_BITS'(q) : DIR_BITS'(q);
      q = ((v[1] << DIR_FRAC_BITS) + (root >> 1)) / root;
      r.dir_y = neg[1] ? -DIR_BITS'(q) : DIR_BITS'(q);
      q = ((v[2] << DIR_FRAC_BITS) + (root >> 1)) / root;
      r.dir_z = neg[2] ? -DIR_BITS'(q) : DIR_BITS'(q);
      return r;
   endfunction

   task automatic send_item(input req_type item);
      while ($urandom_range(0, 3) == 0 && !quiet_tail) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (item.opcode == OP_RAY)
         expected_dirs.push_back(predict_ray(item.screen_x, item.screen_y));
      else if (item.coeff_index < TABLE_DEPTH)
         camera_coeff[item.coeff_index] = item.coeff_value;
   endtask

   function automatic req_type write_item(input int idx, input logic [31:0] val);
      req_type t;
      t = req_type'(REQ_BITS'({$urandom, $urandom, $urandom}));
      t.opcode = OP_WRITE;
      t.coeff_index = IDX_BITS'(idx);
      t.coeff_value = val;
      return t;
   endfunction

   function automatic req_type ray_item(input logic [15:0] x, input logic [15:0] y);
      req_type t;
      t = req_type'(REQ_BITS'({$urandom, $urandom, $urandom}));
      t.opcode = OP_RAY;
      t.screen_x = x;
      t.screen_y = y;
      return t;
   endfunction

   typedef struct {
      req_type item;
      bit      check_typed;
      rsp_type typed;
   } directed_row_type;

   initial begin
      directed_row_type rows [$];
      rsp_type          z;
      int               lim;
      for (int i = 0; i < TABLE_DEPTH; i++) camera_coeff[i] = '0;
      z = '0;
      z.zero_length = 1'b1;
      rows.push_back('{ray_item(16'h0000, 16'h0000), 1, z});
      rows.push_back('{ray_item(16'hFFFF, 16'hFFFF), 1, z});
      rows.push_back('{write_item(15, 32'h7FFF_FFFF), 0, '0});
      rows.push_back('{ray_item(16'h1234, 16'h4321), 1, z});
      rows.push_back('{write_item(2, 32'h1000_0000), 0, '0});
      z = '0;
      z.dir_x = 16'sd16384;
      rows.push_back('{ray_item(16'hFFFF, 16'h0000), 1, z});
      rows.push_back('{write_item(2, 32'h8000_0000), 0, '0});
      z.dir_x = -16'sd16384;
      rows.push_back('{ray_item(16'h0000, 16'hFFFF), 1, z});
      rows.push_back('{write_item(0, 32'h7FFF_FFFF), 0, '0});
      rows.push_back('{write_item(4, 32'h8000_0000), 0, '0});
      rows.push_back('{write_item(8, 32'h7FFF_FFFF), 0, '0});
      rows.push_back('{write_item(1, 32'h0000_0001), 0, '0});
      rows.push_back('{write_item(3, 32'hFFFF_FFFF), 0, '0});
      rows.push_back('{write_item(5, 32'h0800_0000), 0, '0});
      rows.push_back('{write_item(6, 32'hF000_0000), 0, '0});
      rows.push_back('{write_item(7, 32'h0000_0010), 0, '0});
      rows.push_back('{ray_item(16'hFFFF, 16'hFFFF), 0, '0});
      rows.push_back('{ray_item(16'h0000, 16'h0000), 0, '0});
      rows.push_back('{ray_item(16'h8000, 16'h0001), 0, '0});
      rows.push_back('{write_item(9, 32'h0), 0, '0});
      rows.push_back('{ray_item(16'h0010, 16'h7FFF), 0, '0});

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         send_item(rows[i].item);
         if (rows[i].check_typed && rows[i].item.opcode == OP_RAY)
            expected_dirs[$] = rows[i].typed;
      end

      long_hold = 1;
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n > N_RANDOM * 9 / 10) quiet_tail = 1;
         if ($urandom_range(0, 9) == 0) begin
            send_item(write_item($urandom_range(0, 15),
               $urandom_range(0, 3) == 0 ? {$urandom_range(0, 1) ? 4'hF : 4'h0, 28'($urandom)}
                                         : $urandom));
         end else begin
            lim = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'h0FFF;
            send_item(ray_item(16'($urandom_range(0, lim)), 16'($urandom_range(0, lim))));
         end
      end
      req_valid <= 1'b0;
      sending_done = 1;
   end

   initial begin
      while (!long_hold) @(posedge clock);
      rsp_ready <= 1'b0;
      repeat (200) @(posedge clock);
      long_hold = 0;
   end

   always @(posedge clock) begin
      if (!reset && !long_hold) begin
         if (quiet_tail) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_dirs.size() == 0) begin
            $display("%0t: unexpected item %h", $realtime, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = expected_dirs.pop_front();
            if (rsp_data.dir_x !== e.dir_x)
               $display("%0t: dir_x expected %0d actual %0d", $realtime, e.dir_x,
                        rsp_data.dir_x);
            if (rsp_data.dir_y !== e.dir_y)
               $display("%0t: dir_y expected %0d actual %0d", $realtime, e.dir_y,
                        rsp_data.dir_y);
            if (rsp_data.dir_z !== e.dir_z)
               $display("%0t: dir_z expected %0d actual %0d", $realtime, e.dir_z,
                        rsp_data.dir_z);
            if (rsp_data.zero_length !== e.zero_length)
               $display("%0t: zero_length expected %0b actual %0b", $realtime,
                        e.zero_length, rsp_data.zero_length);
            if (rsp_data !== e) errors++;
         end
      end
   end

   initial begin
      while (!(sending_done && expected_dirs.size() == 0) && cycle_count < MAX_CYCLE)
         @(posedge clock);
      if (cycle_count >= MAX_CYCLE) begin
         $display("screen_ray_direction_generator: mismatch");
      end else begin
         repeat (2 * LATENCY) @(posedge clock);
         if (errors == 0)
            $display("screen_ray_direction_generator: match");
         else
            $display("screen_ray_direction_generator: mismatch");
      end
      $finish;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

endmodule

// ===== sim.f =====
+incdir+sv
sv/srdg_pkg.sv
sv/srdg_front.sv
sv/srdg_sqrt.sv
sv/srdg_div.sv
sv/screen_ray_direction_generator.sv
sv/srdg_checker.sv
sim/tb_top.sv
